@@ rtl/irdf_pkg.sv @@
// Shared constants, types and tables of the IR ring direction finder.
package irdf_pkg;

	localparam int COUNT_BITS = 12;
	localparam int FRAC_BITS  = 8;
	localparam int NUM_CH     = 8;
	localparam int CH_W       = 3;
	localparam int STEPS      = 16;
	localparam int STEP_W     = 4;
	localparam int S_W        = 12 + FRAC_BITS;
	localparam int DIAG_SHIFT = 14;
	localparam int D_W        = S_W + 3;
	localparam int E_W        = S_W + 1;
	localparam int V_W        = 17 + D_W + 1;
	localparam int C_W        = V_W + 2;
	localparam int Z_W        = 26;
	localparam int DEG_W      = Z_W - 16;

	localparam logic [11:0] WINDOW_RST = 12'd3000;
	localparam logic [15:0] DIAG_RST   = 16'd11585;
	localparam logic [12:0] BLEND_OLD  = 13'd6554;
	localparam logic [15:0] BLEND_NEW  = 16'd58982;

	localparam int PADDR_W = 3;
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_DIAG   = 1'b1;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_BLEND,
		ST_SUM1,
		ST_SUM2,
		ST_PRE,
		ST_ROT,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PH_MUL,
		PH_GAIN,
		PH_SAT
	} blend_ph_t;

	typedef struct packed {
		logic              acc_en;
		logic              blend;
		blend_ph_t         phase;
		logic [CH_W-1:0]   ch;
		logic              sum1;
		logic              sum2;
		logic              pre;
		logic              rot;
		logic [STEP_W-1:0] step;
		logic              fin;
	} cmd_t;

	typedef struct packed {
		logic win_end;
		logic out_free;
	} status_t;

	// Per-channel gain, Q0.16
	function automatic logic [15:0] gain_q16(input logic [CH_W-1:0] ch);
		logic [15:0] g;
		case (ch)
			3'd0: g = 16'd64927;
			3'd1: g = 16'd64193;
			3'd2: g = 16'd64193;
			3'd3: g = 16'd61112;
			3'd4: g = 16'd59802;
			3'd5: g = 16'd58452;
			3'd6: g = 16'd63406;
			3'd7: g = 16'd63386;
			default: g = 16'd0;
		endcase
		return g;
	endfunction

	// atan(2^-i) in degrees, Q.16
	function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [21:0] a;
		case (i)
			4'd0:  a = 22'd2949120;
			4'd1:  a = 22'd1740967;
			4'd2:  a = 22'd919879;
			4'd3:  a = 22'd466945;
			4'd4:  a = 22'd234379;
			4'd5:  a = 22'd117304;
			4'd6:  a = 22'd58666;
			4'd7:  a = 22'd29335;
			4'd8:  a = 22'd14668;
			4'd9:  a = 22'd7334;
			4'd10: a = 22'd3667;
			4'd11: a = 22'd1833;
			4'd12: a = 22'd917;
			4'd13: a = 22'd458;
			4'd14: a = 22'd229;
			4'd15: a = 22'd115;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/irdf_if.sv @@
// Sample and result channel interfaces of the IR ring direction finder.
interface irdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] sensor_bits;
	modport source(output valid, output sensor_bits, input ready);
	modport sink(input valid, input sensor_bits, output ready);
endinterface

interface irdf_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] direction_deg;
	logic [11:0]       strength_0;
	logic [11:0]       strength_45;
	logic [11:0]       strength_90;
	logic [11:0]       strength_135;
	logic [11:0]       strength_180;
	logic [11:0]       strength_225;
	logic [11:0]       strength_270;
	logic [11:0]       strength_315;
	modport source(output valid, output direction_deg, output strength_0, output strength_45,
		output strength_90, output strength_135, output strength_180, output strength_225,
		output strength_270, output strength_315, input ready);
	modport sink(input valid, input direction_deg, input strength_0, input strength_45,
		input strength_90, input strength_135, input strength_180, input strength_225,
		input strength_270, input strength_315, output ready);
endinterface

@@ rtl/irdf_ctrl.sv @@
// Sequencer of the IR ring direction finder: window end, blend, vector sum, CORDIC.
module irdf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  irdf_pkg::status_t st,
	output irdf_pkg::cmd_t    cmd
);
	import irdf_pkg::*;

	state_t            state_q, state_d;
	blend_ph_t         ph_q;
	logic [CH_W-1:0]   ch_q;
	logic [STEP_W-1:0] step_q;

	// State register and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			ph_q    <= PH_MUL;
			ch_q    <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_BLEND) begin
				case (ph_q)
					PH_MUL:  ph_q <= PH_GAIN;
					PH_GAIN: ph_q <= PH_SAT;
					default: begin
						ph_q <= PH_MUL;
						ch_q <= ch_q + 1'b1;
					end
				endcase
			end
			if (state_q == ST_ROT)
				step_q <= step_q + 1'b1;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC:   if (st.win_end) state_d = ST_BLEND;
			ST_BLEND: if (ph_q == PH_SAT && ch_q == CH_W'(NUM_CH - 1)) state_d = ST_SUM1;
			ST_SUM1:  state_d = ST_SUM2;
			ST_SUM2:  state_d = ST_PRE;
			ST_PRE:   state_d = ST_ROT;
			ST_ROT:   if (step_q == STEP_W'(STEPS - 1)) state_d = ST_FIN;
			ST_FIN:   if (st.out_free) state_d = ST_ACC;
			default:  state_d = ST_ACC;
		endcase
	end

	// Commands
	always_comb begin
		cmd        = '0;
		cmd.phase  = ph_q;
		cmd.ch     = ch_q;
		cmd.step   = step_q;
		cmd.acc_en = (state_q == ST_ACC);
		cmd.blend  = (state_q == ST_BLEND);
		cmd.sum1   = (state_q == ST_SUM1);
		cmd.sum2   = (state_q == ST_SUM2);
		cmd.pre    = (state_q == ST_PRE);
		cmd.rot    = (state_q == ST_ROT);
		cmd.fin    = (state_q == ST_FIN) && st.out_free;
	end

endmodule

@@ rtl/irdf_dp.sv @@
// Datapath of the IR ring direction finder: counters, smoothing, vector sum, CORDIC, output word.
module irdf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  irdf_pkg::cmd_t    cmd,
	output irdf_pkg::status_t st,
	input  logic [11:0]       window_length,
	input  logic [15:0]       diagonal_weight,
	irdf_in_if.sink           samples,
	irdf_out_if.source        result
);
	import irdf_pkg::*;

	localparam int PA_W  = S_W + 13;
	localparam int PB_W  = COUNT_BITS + 16;
	localparam int SUM_W = PB_W + FRAC_BITS + 2;
	localparam int B_W   = SUM_W - 16;
	localparam int PR_W  = B_W + 16;
	localparam logic [S_W-1:0] SMAX = {S_W{1'b1}};
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] cnt_q [NUM_CH];
	logic [S_W-1:0]        str_q [NUM_CH];
	logic [11:0]           samp_q;
	logic [11:0]           samp_nx;
	logic [11:0]           win;
	logic                  accept;
	logic                  hit;

	logic [PA_W-1:0]  pa_q;
	logic [PB_W-1:0]  pb_q;
	logic [PR_W-1:0]  prod_q;
	logic [SUM_W-1:0] bsum;
	logic [B_W-1:0]   bval;
	logic [PR_W:0]    rsum;
	logic [PR_W-16:0] rval;
	logic [S_W-1:0]   snew;

	logic signed [D_W-1:0] dy_q, dx_q;
	logic signed [E_W-1:0] ey_q, ex_q;
	logic signed [V_W-1:0] y_q, x_q;
	logic signed [16:0]    w_s;
	logic signed [C_W-1:0] u_q, v_q, du, dv;
	logic signed [Z_W-1:0] z_q, zr, atan_s;
	logic                  zero_q;
	logic signed [DEG_W-1:0] deg;
	logic signed [DEG_W-1:0] deg_w;

	logic              out_v_q;
	logic signed [8:0] dir_q;
	logic [11:0]       so_q [NUM_CH];

	// Window bookkeeping
	assign samples.ready = cmd.acc_en;
	assign accept  = samples.valid && cmd.acc_en;
	assign win     = (window_length == 12'd0) ? 12'd1 : window_length;
	assign samp_nx = samp_q + 12'd1;
	assign hit     = (samp_nx >= win) || (samp_nx == 12'd0);
	assign st.win_end  = accept && hit;
	assign st.out_free = !out_v_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_q <= '0;
		end else if (accept) begin
			samp_q <= hit ? 12'd0 : samp_nx;
		end
	end

	// Count low samples per channel; clear each after its blend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CH; k++) cnt_q[k] <= '0;
		end else begin
			for (int k = 0; k < NUM_CH; k++) begin
				if (accept && !samples.sensor_bits[k] && cnt_q[k] != CMAX)
					cnt_q[k] <= cnt_q[k] + 1'b1;
				if (cmd.blend && cmd.phase == PH_SAT && cmd.ch == CH_W'(k))
					cnt_q[k] <= '0;
			end
		end
	end

	// Blend old strength with new count, then apply channel gain
	assign bsum = SUM_W'(pa_q) + (SUM_W'(pb_q) << FRAC_BITS) + SUM_W'(32768);
	assign bval = bsum[SUM_W-1:16];
	assign rsum = (PR_W+1)'(prod_q) + (PR_W+1)'(32768);
	assign rval = rsum[PR_W:16];
	assign snew = (rval > (PR_W-15)'(SMAX)) ? SMAX : S_W'(rval);

	always_ff @(posedge clk) begin
		if (cmd.blend) begin
			case (cmd.phase)
				PH_MUL: begin
					pa_q <= PA_W'(str_q[cmd.ch]) * PA_W'(BLEND_OLD);
					pb_q <= PB_W'(cnt_q[cmd.ch]) * PB_W'(BLEND_NEW);
				end
				PH_GAIN: prod_q <= PR_W'(bval) * PR_W'(gain_q16(cmd.ch));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CH; k++) str_q[k] <= '0;
		end else if (cmd.blend && cmd.phase == PH_SAT) begin
			str_q[cmd.ch] <= snew;
		end
	end

	// Vector sum with weighted diagonals
	assign w_s = {1'b0, diagonal_weight};

	always_ff @(posedge clk) begin
		if (cmd.sum1) begin
			ey_q <= E_W'(str_q[0]) - E_W'(str_q[4]);
			ex_q <= E_W'(str_q[2]) - E_W'(str_q[6]);
			dy_q <= D_W'(str_q[1]) + D_W'(str_q[7]) - D_W'(str_q[3]) - D_W'(str_q[5]);
			dx_q <= D_W'(str_q[1]) + D_W'(str_q[3]) - D_W'(str_q[5]) - D_W'(str_q[7]);
		end
		if (cmd.sum2) begin
			y_q <= (V_W'(ey_q) <<< DIAG_SHIFT) + V_W'(w_s) * V_W'(dy_q);
			x_q <= (V_W'(ex_q) <<< DIAG_SHIFT) + V_W'(w_s) * V_W'(dx_q);
		end
	end

	// CORDIC vectoring: prerotate into the right half plane, then one step a cycle
	assign du     = v_q >>> cmd.step;
	assign dv     = u_q >>> cmd.step;
	assign atan_s = Z_W'(signed'({1'b0, atan_q16(cmd.step)}));

	always_ff @(posedge clk) begin
		if (cmd.pre) begin
			zero_q <= (x_q == '0) && (y_q == '0);
			if (y_q < 0) begin
				if (x_q >= 0) begin
					u_q <= C_W'(x_q);
					v_q <= -C_W'(y_q);
					z_q <= Z_W'(90 * 65536);
				end else begin
					u_q <= -C_W'(x_q);
					v_q <= C_W'(y_q);
					z_q <= -Z_W'(90 * 65536);
				end
			end else begin
				u_q <= C_W'(y_q);
				v_q <= C_W'(x_q);
				z_q <= '0;
			end
		end else if (cmd.rot) begin
			if (v_q >= 0) begin
				u_q <= u_q + du;
				v_q <= v_q - dv;
				z_q <= z_q + atan_s;
			end else begin
				u_q <= u_q - du;
				v_q <= v_q + dv;
				z_q <= z_q - atan_s;
			end
		end
	end

	// Round to whole degrees and wrap into [-180,179]
	assign zr  = z_q + Z_W'(32768);
	assign deg = zr[Z_W-1:16];
	always_comb begin
		if (zero_q)
			deg_w = DEG_W'(90);
		else if (deg >= DEG_W'(180))
			deg_w = deg - DEG_W'(360);
		else if (deg < -DEG_W'(180))
			deg_w = deg + DEG_W'(360);
		else
			deg_w = deg;
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.fin)
			out_v_q <= 1'b1;
		else if (result.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			dir_q <= 9'(deg_w);
			for (int k = 0; k < NUM_CH; k++) so_q[k] <= str_q[k][S_W-1:FRAC_BITS];
		end
	end

	assign result.valid         = out_v_q;
	assign result.direction_deg = dir_q;
	assign result.strength_0    = so_q[0];
	assign result.strength_45   = so_q[1];
	assign result.strength_90   = so_q[2];
	assign result.strength_135  = so_q[3];
	assign result.strength_180  = so_q[4];
	assign result.strength_225  = so_q[5];
	assign result.strength_270  = so_q[6];
	assign result.strength_315  = so_q[7];

endmodule

@@ rtl/ir_ring_direction_finder.sv @@
// Top level of the IR ring direction finder: register port, sequencer and datapath.
// One sample word is taken per clock while a window fills. When the last sample of a window
// is taken, the block stops taking samples while it runs the smoothing multiplies (multiply,
// gain and saturate phases per channel), the vector sum, prerotation and 16 CORDIC steps on
// the shared shift-add unit, and loads the result word, which waits while the previous one
// is still held. Registers: 0x0 window_length, 0x4 diagonal_weight (Q2.14); write them
// only while the block is idle.
module ir_ring_direction_finder (
	input  logic                          clk,
	input  logic                          arst_n,
	irdf_in_if.sink                       samples,
	irdf_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [irdf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import irdf_pkg::*;

	logic [11:0] window_q;
	logic [15:0] diag_q;
	logic        wr;
	cmd_t        cmd;
	status_t     st;

	// Register port
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			diag_q   <= DIAG_RST;
		end else if (wr) begin
			case (paddr[2])
				REG_WINDOW: window_q <= pwdata[11:0];
				REG_DIAG:   diag_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WINDOW: prdata = {20'd0, window_q};
			REG_DIAG:   prdata = {16'd0, diag_q};
			default:    prdata = '0;
		endcase
	end

	irdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	irdf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.window_length   (window_q),
		.diagonal_weight (diag_q),
		.samples         (samples),
		.result          (result)
	);

endmodule
